// File: rtl/core/dbmc_pkg.sv
`timescale 1ns / 1ps
package dbmc_pkg;

  // operating modes
  localparam logic [1:0] MODE_DECOMP  = 2'd0;
  localparam logic [1:0] MODE_COMPOSE = 2'd1;
  localparam logic [1:0] MODE_FIND    = 2'd2;

  localparam int unsigned MAX_FIND_BYTES = 6;
  localparam logic [62:0] INF_MAG        = 63'h7FF0000000000000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] value_bits;
    logic [2:0]  byte_count;
    logic [7:0]  exponent_in;
    logic [55:0] mantissa_in;
    logic        last_in_group;
  } in_item_t;

  typedef struct packed {
    logic [63:0] value_out;
    logic [7:0]  exponent_out;
    logic [55:0] mantissa_out;
    logic [2:0]  bytes_needed;
    logic        error_flag;
  } out_item_t;

endpackage

// File: rtl/core/dbmc_if.sv
`timescale 1ns / 1ps
interface dbmc_in_if;
  logic               valid;
  logic               ready;
  dbmc_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dbmc_out_if;
  logic                valid;
  logic                ready;
  dbmc_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/double_byte_mantissa_codec.sv
`timescale 1ns / 1ps
// Sequence: an accepted item is unpacked (S_NORM) and worked (S_WORK); find on a
// nonzero finite value then tries mantissa widths 1..6 in S_FIND, and every item
// ends in S_DONE, which raises the result. One item at a time: a new item is
// taken only after the previous result is accepted.
// Reset (rst, synchronous): sequencer idle, no result pending, threshold and
// group maximum cleared.
module double_byte_mantissa_codec (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [62:0]   cfg_wdata,
  dbmc_in_if.sink       in_ch,
  dbmc_out_if.source    out_ch
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_NORM = 3'd1;
  localparam logic [2:0] S_WORK = 3'd2;
  localparam logic [2:0] S_FIND = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]  state, state_next;
  logic [62:0] max_error;
  logic [2:0]  group_max_bytes;
  dbmc_pkg::in_item_t item;
  logic        out_valid;
  dbmc_pkg::out_item_t res;
  dbmc_pkg::out_item_t work_res;

  // normalized operand
  logic [52:0] m53;
  logic signed [12:0] e;
  logic [2:0]  n;
  logic [2:0]  try_n;

  // leading-one position of a 64-bit word (priority search)
  function automatic logic [5:0] top_bit(input logic [63:0] x);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) p = 6'(i);
    end
    return p;
  endfunction

  // rounding function: round m53 to k = 8t-2 bits, half away from zero
  function automatic logic [53:0] round_to(input logic [52:0] m, input logic [2:0] t);
    logic [5:0]  s;
    logic [53:0] r;
    s = 6'(53 - (8 * t - 2));
    r = ({1'b0, m} + (54'd1 << (s - 6'd1))) >> s;
    return r;
  endfunction

  assign in_ch.ready  = (state == S_IDLE) && !out_valid;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = res;

  // unit outputs for the current width
  logic [5:0]  fs;
  logic [53:0] fr;
  logic [53:0] fback;
  logic [52:0] fd;
  logic [5:0]  fp;
  logic signed [13:0] fex;
  logic [62:0] ferr;
  logic signed [13:0] fsh;
  logic        fover;

  always_comb begin
    fs    = 6'(53 - (8 * try_n - 2));
    fr    = round_to(m53, try_n);
    fback = fr << fs;
    fd    = (fback > {1'b0, m53}) ? 53'(fback - {1'b0, m53}) : 53'({1'b0, m53} - fback);
    fp    = top_bit({11'd0, fd});
    fex   = 14'(signed'({1'b0, fp})) + 14'(e) - 14'sd53;
    fsh   = 14'(e) - 14'sd53 + 14'sd1074;
    fover = (fr == (54'd1 << (8 * try_n - 2))) && (e >= 13'sd1024);
    if (fover) begin
      ferr = dbmc_pkg::INF_MAG;
    end else if (fd == '0) begin
      ferr = '0;
    end else if (fex >= -14'sd1022) begin
      ferr = {11'(fex + 14'sd1023), 52'({11'd0, fd} << (6'd52 - fp))};
    end else if (fsh >= 0) begin
      ferr = 63'({10'd0, fd} << fsh[5:0]);
    end else begin
      ferr = 63'({10'd0, fd} >> 6'(-fsh));
    end
  end

  // decompose / compose datapath on the registered item
  logic [5:0]  dk;
  logic [53:0] dm;
  logic signed [13:0] dea;
  logic [55:0] cm;
  logic        cneg;
  logic [5:0]  cp;
  logic [5:0]  cs;
  logic [55:0] crem, chalf, cmant;
  logic [52:0] cman;
  logic [5:0]  cpp;
  logic        special;
  logic [62:0] mag;

  always_comb begin
    mag     = item.value_bits[62:0];
    special = &item.value_bits[62:52];
    dk      = 6'(8 * n - 2);
    dm      = (mag == '0) ? '0 :
              ((dk >= 6'd53) ? ({1'b0, m53} << (dk - 6'd53)) : round_to(m53, n));
    dea     = ((mag == '0) ? 14'sd0 : 14'(e)) - 14'(signed'({1'b0, dk}));
    cm      = item.mantissa_in & ~(56'd1 << (8 * n - 1));
    cneg    = item.mantissa_in[8 * n - 1];
    cp      = top_bit({8'd0, cm});
    cs      = (cp > 6'd52) ? 6'(cp - 6'd52) : 6'd0;
    crem    = cm & ((56'd1 << cs) - 56'd1);
    chalf   = (cs == 0) ? 56'd0 : (56'd1 << (cs - 6'd1));
    cmant   = (cp <= 6'd52) ? (cm << (6'd52 - cp)) : (cm >> cs);
    cpp     = cp;
    if (cp > 6'd52 && (crem > chalf || (crem == chalf && cmant[0]))) begin
      cmant = cmant + 56'd1;
    end
    if (cmant[53]) begin
      cmant = cmant >> 1;
      cpp   = cp + 6'd1;
    end
    cman = cmant[52:0];
  end

  // result fields per mode, loaded into the result register in S_WORK; find adds bytes_needed in S_DONE
  always_comb begin
    work_res = '0;
    case (item.mode)
      dbmc_pkg::MODE_DECOMP: begin
        if (special || dea > 14'sd127) begin
          work_res.error_flag = 1'b1;
        end else if (dea > -14'sd128) begin
          work_res.exponent_out = dea[7:0];
          work_res.mantissa_out = 56'(dm) |
            ((item.value_bits[63] && mag != '0) ? (56'd1 << (8 * n - 1)) : 56'd0);
        end
      end
      dbmc_pkg::MODE_COMPOSE: begin
        if (cm != '0) begin
          work_res.value_out = {cneg,
            11'(14'(signed'({1'b0, cpp})) + 14'(signed'(item.exponent_in)) +
                14'sd1023),
            cman[51:0]};
        end
      end
      dbmc_pkg::MODE_FIND: work_res.error_flag = special;
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_ch.valid && in_ch.ready) state_next = S_NORM;
      S_NORM:  state_next = S_WORK;
      S_WORK:  state_next = (item.mode == dbmc_pkg::MODE_FIND && !special &&
                             mag != '0) ? S_FIND : S_DONE;
      S_FIND:  if (try_n == 3'(dbmc_pkg::MAX_FIND_BYTES) ||
                   max_error > dbmc_pkg::INF_MAG || !(ferr > max_error))
                 state_next = S_DONE;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  logic [2:0] used;
  logic [2:0] gmax;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      max_error       <= '0;
      group_max_bytes <= '0;
      out_valid       <= 1'b0;
      used            <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) max_error <= cfg_wdata;
      if (out_ch.valid && out_ch.ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            item  <= in_ch.data;
            n     <= (in_ch.data.byte_count == '0) ? 3'd1 : in_ch.data.byte_count;
            try_n <= 3'd1;
          end
        end
        S_NORM: begin
          // unpack a nonzero value to a 53-bit significand with bit 52 set
          if (item.value_bits[62:52] != '0) begin
            m53 <= {1'b1, item.value_bits[51:0]};
            e   <= 13'(signed'({2'b0, item.value_bits[62:52]})) - 13'sd1022;
          end else begin
            m53 <= 53'({1'b0, item.value_bits[51:0]} <<
                   (6'd52 - top_bit({12'd0, item.value_bits[51:0]})));
            e   <= 13'(signed'({7'd0, top_bit({12'd0, item.value_bits[51:0]})})) -
                   13'sd1073;
          end
        end
        S_WORK: begin
          res  <= work_res;
          used <= special ? 3'(dbmc_pkg::MAX_FIND_BYTES) : 3'd1;
        end
        S_FIND: begin
          used  <= try_n;
          try_n <= try_n + 3'd1;
        end
        S_DONE: begin
          out_valid <= 1'b1;
          if (item.mode == dbmc_pkg::MODE_FIND) begin
            res.bytes_needed <= gmax;
            group_max_bytes  <= item.last_in_group ? 3'd0 : gmax;
          end
        end
        default: ;
      endcase
    end
  end

  assign gmax = (used > group_max_bytes) ? used : group_max_bytes;

endmodule

// File: test/tb_double_byte_mantissa_codec.sv
`timescale 1ns / 1ps
module tb_double_byte_mantissa_codec;
  import dbmc_pkg::*;

  localparam logic [1:0]  MODE_IDLE    = 2'd3;
  localparam logic [63:0] FRAC_BITS    = 64'h000F_FFFF_FFFF_FFFF;
  localparam logic [63:0] INF_PATTERN  = 64'h7FF0_0000_0000_0000;
  localparam logic [62:0] MAX_FINITE   = 63'h7FEF_FFFF_FFFF_FFFF;
  localparam int          CYCLE_LIMIT  = 600000;
  localparam int          DRAIN_CYCLES = 14;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [62:0] cfg_wdata = '0;

  dbmc_in_if  in_ch ();
  dbmc_out_if out_ch ();

  double_byte_mantissa_codec i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source)
  );

  always #6 clk = ~clk;

  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  logic [62:0] threshold_bits;
  logic [2:0]  group_peak;
  int  cycle_count;
  bit  failed;

  // ---------------- prediction ----------------

  function automatic int msb_pos(logic [63:0] x);
    int p;
    p = 0;
    for (int i = 1; i < 64; i++) if (x[i]) p = i;
    return p;
  endfunction

  // nonzero finite magnitude -> sig * 2^(ex-53), bit 52 of sig set
  function automatic void split_double(input logic [63:0] bits, output logic [63:0] sig,
                                       output int ex);
    logic [10:0] be;
    logic [63:0] fr;
    int p;
    be = bits[62:52];
    fr = bits & FRAC_BITS;
    if (be != 0) begin
      sig = fr | (64'd1 << 52);
      ex  = int'(be) - 1022;
    end else begin
      p   = msb_pos(fr);
      sig = fr << (52 - p);
      ex  = p - 1073;
    end
  endfunction

  // round half away from zero to k bits
  function automatic logic [63:0] round_sig(logic [63:0] sig, int k);
    int s;
    if (k >= 53) return sig << (k - 53);
    s = 53 - k;
    return (sig + (64'd1 << (s - 1))) >> s;
  endfunction

  // double pattern of d * 2^x (subnormal results truncated)
  function automatic logic [63:0] err_pattern(logic [63:0] d, int x);
    int p, ex, sh;
    if (d == 0) return '0;
    p  = msb_pos(d);
    ex = p + x;
    if (ex >= -1022) return (64'(ex + 1023) << 52) | ((d << (52 - p)) & FRAC_BITS);
    sh = x + 1074;
    if (sh >= 0) return (sh < 64) ? d << sh : '0;
    return (-sh < 64) ? d >> (-sh) : '0;
  endfunction

  function automatic int bytes_for_value(logic [63:0] bits);
    logic [63:0] sig, r, back, d, err;
    int ex, k, s;
    bit thr_nan;
    thr_nan = {1'b0, threshold_bits} > INF_PATTERN;
    if (bits[62:0] == 0) return 1;
    split_double({1'b0, bits[62:0]}, sig, ex);
    for (int n = 1; n <= MAX_FIND_BYTES; n++) begin
      k = 8 * n - 2;
      s = 53 - k;
      r = round_sig(sig, k);
      if (r == (64'd1 << k) && ex >= 1024) begin
        err = INF_PATTERN;
      end else begin
        back = r << s;
        d    = (back > sig) ? back - sig : sig - back;
        err  = err_pattern(d, ex - 53);
      end
      if (n == MAX_FIND_BYTES || thr_nan || !(err > {1'b0, threshold_bits})) return n;
    end
    return MAX_FIND_BYTES;
  endfunction

  function automatic out_item_t codec_result(in_item_t it);
    out_item_t res;
    logic [63:0] sig, m, sbit, mant, half, rem;
    int n, k, ex, ea, p, s, used;
    bit special, neg;
    res = '0;
    n = (it.byte_count == 0) ? 1 : int'(it.byte_count);
    special = (it.value_bits[62:52] == 11'h7FF);
    case (it.mode)
      MODE_DECOMP: begin
        k = 8 * n - 2;
        m = '0;
        ex = 0;
        if (special) begin
          res.error_flag = 1'b1;
          return res;
        end
        if (it.value_bits[62:0] != 0) begin
          split_double({1'b0, it.value_bits[62:0]}, sig, ex);
          m = round_sig(sig, k);
        end
        ea = ex - k;
        if (ea <= -128) return res;
        if (ea > 127) begin
          res.error_flag = 1'b1;
          return res;
        end
        if (it.value_bits[63] && it.value_bits[62:0] != 0) m = m | (64'd1 << (8 * n - 1));
        res.exponent_out = ea[7:0];
        res.mantissa_out = m[55:0];
      end
      MODE_COMPOSE: begin
        ex   = int'($signed(it.exponent_in));
        m    = 64'(it.mantissa_in);
        sbit = 64'd1 << (8 * n - 1);
        neg  = 1'b0;
        if ((m & sbit) != 0) begin
          m   = m ^ sbit;
          neg = 1'b1;
        end
        if (m == 0) return res;
        p = msb_pos(m);
        if (p <= 52) begin
          mant = m << (52 - p);
        end else begin
          // nearest, ties to even
          s    = p - 52;
          half = 64'd1 << (s - 1);
          rem  = m & ((64'd1 << s) - 1);
          mant = m >> s;
          if (rem > half || (rem == half && mant[0])) mant = mant + 1;
          if (mant == (64'd1 << 53)) begin
            mant = mant >> 1;
            p = p + 1;
          end
        end
        res.value_out = ({63'd0, neg} << 63) | (64'(p + ex + 1023) << 52) | (mant & FRAC_BITS);
      end
      MODE_FIND: begin
        if (special) begin
          res.error_flag = 1'b1;
          used = MAX_FIND_BYTES;
        end else begin
          used = bytes_for_value(it.value_bits);
        end
        if (used > int'(group_peak)) group_peak = 3'(used);
        res.bytes_needed = group_peak;
        if (it.last_in_group) group_peak = '0;
      end
      default: ;
    endcase
    return res;
  endfunction

  // ---------------- stimulus helpers ----------------

  function automatic logic [63:0] rand_double();
    logic [63:0] v;
    int pos;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 11))
      0: v[62:0] = '0;
      1: v[62:52] = '0;                              // subnormal
      2: v[62:52] = 11'h7FF;                         // inf or NaN
      3: begin                                       // exact halfway patterns
        v[62:52] = 11'($urandom_range(900, 1150));
        pos = $urandom_range(0, 51);
        v[51:0] = v[51:0] & ~((52'd1 << (pos + 1)) - 1);
        v[pos] = 1'b1;
      end
      4: v[62:52] = 11'($urandom_range(2030, 2046)); // top of range
      5: v[62:52] = 11'($urandom_range(1, 2046));
      6: v[51:0] = {52{1'b1}} ^ 52'($urandom_range(0, 3));
      default: v[62:52] = 11'($urandom_range(870, 1180));
    endcase
    if (v[62:52] == 11'h7FF && $urandom_range(0, 1)) v[51:0] = '0;
    return v;
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    int n, w;
    it.mode          = 2'($urandom_range(0, 9) == 0 ? MODE_IDLE : $urandom_range(0, 2));
    it.value_bits    = rand_double();
    it.byte_count    = 3'($urandom_range(0, 7));
    it.exponent_in   = 8'($urandom);
    it.mantissa_in   = 56'({$urandom, $urandom});
    it.last_in_group = ($urandom_range(0, 3) == 0);
    if (it.mode == MODE_FIND) it.byte_count = 3'($urandom);
    if (it.mode == MODE_COMPOSE) begin
      n = (it.byte_count == 0) ? 1 : int'(it.byte_count);
      w = 8 * n;
      // mostly mantissas within the field, some with a short magnitude
      if ($urandom_range(0, 5) != 0 && w < 56)
        it.mantissa_in = it.mantissa_in & ((56'd1 << w) - 1);
      if ($urandom_range(0, 7) == 0)
        it.mantissa_in = it.mantissa_in & 56'($urandom_range(0, 255));
    end
    return it;
  endfunction

  function automatic in_item_t make_item(logic [1:0] mode, logic [63:0] v, logic [2:0] n,
                                         logic [7:0] ex, logic [55:0] m, logic last);
    in_item_t it;
    it.mode = mode;
    it.value_bits = v;
    it.byte_count = n;
    it.exponent_in = ex;
    it.mantissa_in = m;
    it.last_in_group = last;
    return it;
  endfunction

  // ---------------- driver ----------------

  int burst_left;
  int gap_left;

  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      burst_left  <= 1;
      gap_left    <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (gap_left > 0) begin
        in_ch.valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_items.size() > 0) begin
        in_ch.data  <= pending_items.pop_front();
        in_ch.valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 16);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // predict on every accepted item
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) expected_results.push_back(codec_result(in_ch.data));
  end

  // ---------------- receiver ----------------

  int stall_style;
  int style_left;

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_style  <= 0;
      style_left   <= 40;
    end else begin
      if (style_left == 0) begin
        stall_style <= $urandom_range(0, 3);
        style_left  <= $urandom_range(20, 200);
      end else begin
        style_left <= style_left - 1;
      end
      case (stall_style)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= ($urandom_range(0, 1) == 0);
        2:       out_ch.ready <= ($urandom_range(0, 4) == 0);
        default: out_ch.ready <= (cycle_count % 7) < 4;
      endcase
    end
  end

  // ---------------- monitor ----------------

  always @(posedge clk) begin
    out_item_t want, got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        failed = 1'b1;
      end else begin
        want = expected_results.pop_front();
        if (got.value_out !== want.value_out) begin
          $display("%0t: value_out expected %h actual %h", $time, want.value_out, got.value_out);
          failed = 1'b1;
        end
        if (got.exponent_out !== want.exponent_out) begin
          $display("%0t: exponent_out expected %h actual %h", $time, want.exponent_out,
                   got.exponent_out);
          failed = 1'b1;
        end
        if (got.mantissa_out !== want.mantissa_out) begin
          $display("%0t: mantissa_out expected %h actual %h", $time, want.mantissa_out,
                   got.mantissa_out);
          failed = 1'b1;
        end
        if (got.bytes_needed !== want.bytes_needed) begin
          $display("%0t: bytes_needed expected %0d actual %0d", $time, want.bytes_needed,
                   got.bytes_needed);
          failed = 1'b1;
        end
        if (got.error_flag !== want.error_flag) begin
          $display("%0t: error_flag expected %b actual %b", $time, want.error_flag,
                   got.error_flag);
          failed = 1'b1;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------- sequence ----------------

  task automatic write_threshold(logic [62:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    threshold_bits = v;
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_ch.valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [62:0] thr_list[5];
    in_ch.valid    = 1'b0;
    in_ch.data     = '0;
    out_ch.ready   = 1'b0;
    threshold_bits = '0;
    group_peak     = '0;
    cycle_count    = 0;
    failed         = 1'b0;
    thr_list[0] = MAX_FINITE;
    thr_list[1] = 63'h3EB0_C6F7_A0B5_ED8D;   // about 1e-6
    thr_list[2] = {1'b0, 11'($urandom_range(900, 1100)), 51'({$urandom, $urandom})};
    thr_list[3] = 63'h3FF0_0000_0000_0000;   // 1.0
    thr_list[4] = '0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    write_threshold('0);

    // directed: field extremes and corner cases
    pending_items.push_back(make_item(MODE_DECOMP, 64'h0, 3'd1, 8'h00, '0, 1'b0));
    pending_items.push_back(make_item(MODE_DECOMP, 64'h8000_0000_0000_0000, 3'd7, 8'h7F,
                                      '1, 1'b1));
    pending_items.push_back(make_item(MODE_DECOMP, 64'h3FF0_0000_0000_0000, 3'd0, 8'h80,
                                      '0, 1'b0));
    pending_items.push_back(make_item(MODE_DECOMP, 64'hBFF8_0000_0000_0000, 3'd3, 8'h00,
                                      '0, 1'b0));
    pending_items.push_back(make_item(MODE_DECOMP, 64'h0000_0000_0000_0001, 3'd7, 8'h00,
                                      '0, 1'b0));
    pending_items.push_back(make_item(MODE_DECOMP, 64'h7FEF_FFFF_FFFF_FFFF, 3'd1, 8'h00,
                                      '0, 1'b0));
    pending_items.push_back(make_item(MODE_DECOMP, 64'hFFF0_0000_0000_0000, 3'd2, 8'h00,
                                      '0, 1'b0));
    pending_items.push_back(make_item(MODE_DECOMP, 64'h7FF8_0000_0000_0001, 3'd2, 8'h00,
                                      '0, 1'b0));
    pending_items.push_back(make_item(MODE_DECOMP, 64'h3FF0_2000_0000_0000, 3'd1, 8'h00,
                                      '0, 1'b0));
    pending_items.push_back(make_item(MODE_DECOMP, 64'h3FEF_FFFF_FFFF_FFFF, 3'd1, 8'h00,
                                      '0, 1'b0));
    pending_items.push_back(make_item(MODE_COMPOSE, '1, 3'd1, 8'h00, 56'h80, 1'b0));
    pending_items.push_back(make_item(MODE_COMPOSE, '0, 3'd0, 8'h80, 56'hC1, 1'b0));
    pending_items.push_back(make_item(MODE_COMPOSE, '0, 3'd7, 8'h7F, '1, 1'b1));
    pending_items.push_back(make_item(MODE_COMPOSE, '0, 3'd7, 8'hC0, 56'h3F_FFFF_FFFF_FFFF,
                                      1'b0));
    pending_items.push_back(make_item(MODE_COMPOSE, '0, 3'd7, 8'h00, 56'h30_0000_0000_0002,
                                      1'b0));
    pending_items.push_back(make_item(MODE_COMPOSE, '0, 3'd2, 8'h00, 56'hFF_0000_0000_0001,
                                      1'b0));
    pending_items.push_back(make_item(MODE_FIND, 64'h0, 3'd0, 8'h00, '0, 1'b0));
    pending_items.push_back(make_item(MODE_FIND, 64'h3FF0_0000_0000_0000, 3'd0, 8'h00,
                                      '0, 1'b1));
    pending_items.push_back(make_item(MODE_FIND, 64'h7FEF_FFFF_FFFF_FFFF, 3'd0, 8'h00,
                                      '0, 1'b0));
    pending_items.push_back(make_item(MODE_FIND, 64'h7FF0_0000_0000_0000, 3'd0, 8'h00,
                                      '0, 1'b1));
    pending_items.push_back(make_item(MODE_FIND, 64'h3FF0_0000_0000_0001, 3'd0, 8'h00,
                                      '0, 1'b1));
    pending_items.push_back(make_item(MODE_IDLE, '1, 3'd7, 8'hFF, '1, 1'b1));
    pending_items.push_back(make_item(MODE_IDLE, '0, 3'd0, 8'h00, '0, 1'b0));
    drain();

    // random phases, one threshold each
    foreach (thr_list[ph]) begin
      write_threshold(thr_list[ph]);
      repeat (325) pending_items.push_back(rand_item());
      drain();
    end

    if (!failed) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
